// File: rtl/core/sppt_pkg.sv
package sppt_pkg;

    // Width of the radius field of one input item.
    localparam int RADIUS_BITS = 30;

    // Register file map of the back end. Vectors take three consecutive entries.
    localparam logic [5:0] R_P1  = 6'd0;
    localparam logic [5:0] R_P2  = 6'd3;
    localparam logic [5:0] R_P3  = 6'd6;
    localparam logic [5:0] R_P4  = 6'd9;
    localparam logic [5:0] R_RS  = 6'd12;
    localparam logic [5:0] R_ZR  = 6'd13;
    localparam logic [5:0] R_R2  = 6'd14;
    localparam logic [5:0] R_D1  = 6'd15;
    localparam logic [5:0] R_D2  = 6'd18;
    localparam logic [5:0] R_N   = 6'd21;
    localparam logic [5:0] R_P31 = 6'd24;
    localparam logic [5:0] R_S   = 6'd27;
    localparam logic [5:0] R_NN  = 6'd28;
    localparam logic [5:0] R_T0  = 6'd29;
    localparam logic [5:0] R_T1  = 6'd30;
    localparam logic [5:0] R_D21 = 6'd31;
    localparam logic [5:0] R_D22 = 6'd32;
    localparam logic [5:0] R_D11 = 6'd33;
    localparam logic [5:0] R_E2  = 6'd34;
    localparam logic [5:0] R_E1  = 6'd35;
    localparam logic [5:0] R_NA  = 6'd36;
    localparam logic [5:0] R_NB  = 6'd37;
    localparam logic [5:0] R_W   = 6'd38;
    localparam logic [5:0] R_A   = 6'd41;
    localparam logic [5:0] R_B   = 6'd42;
    localparam logic [5:0] R_WW  = 6'd43;
    localparam logic [5:0] R_E   = 6'd44;
    // Aliases resolved by the endpoint pass: query point, segment origin, direction.
    localparam logic [5:0] R_VQ  = 6'd48;
    localparam logic [5:0] R_VO  = 6'd51;
    localparam logic [5:0] R_VD  = 6'd54;

    // Program labels.
    localparam logic [5:0] L_LINE = 6'd15;
    localparam logic [5:0] L_HIT  = 6'd36;
    localparam logic [5:0] L_NEAR = 6'd37;
    localparam logic [5:0] L_CMPW = 6'd50;
    localparam logic [5:0] L_ENDP = 6'd52;
    localparam logic [5:0] L_MISS = 6'd56;

    typedef enum logic [3:0] {
        OP_SUB,
        OP_VSUB,
        OP_MUL,
        OP_DOT,
        OP_BLT,
        OP_BLE,
        OP_BGT,
        OP_BGE,
        OP_BEQ,
        OP_BNE,
        OP_HIT,
        OP_MISS,
        OP_NXT
    } t_op;

    // For branches the d field holds the target address.
    typedef struct packed {
        t_op        op;
        logic [5:0] d;
        logic [5:0] a;
        logic [5:0] b;
    } t_instr;

    typedef enum logic [2:0] {
        B_IDLE,
        B_LOAD,
        B_RD,
        B_EX,
        B_MUL,
        B_DONE
    } t_bstate;

    function automatic t_instr f_mk(input t_op op, input logic [5:0] d,
                                    input logic [5:0] a, input logic [5:0] b);
        t_instr u;
        u.op = op;
        u.d  = d;
        u.a  = a;
        u.b  = b;
        return u;
    endfunction

    // Program of the back end.
    function automatic t_instr f_ucode(input logic [5:0] pc);
        t_instr u;
        u = f_mk(OP_MISS, 6'd0, 6'd0, 6'd0);
        case (pc)
            // Radius limit, directions and the cross product of the directions.
            6'd0:  u = f_mk(OP_MUL,  R_R2, R_RS, R_RS);
            6'd1:  u = f_mk(OP_VSUB, R_D1, R_P2, R_P1);
            6'd2:  u = f_mk(OP_VSUB, R_D2, R_P4, R_P3);
            6'd3:  u = f_mk(OP_MUL,  R_T0, R_D1 + 6'd1, R_D2 + 6'd2);
            6'd4:  u = f_mk(OP_MUL,  R_T1, R_D1 + 6'd2, R_D2 + 6'd1);
            6'd5:  u = f_mk(OP_SUB,  R_N, R_T0, R_T1);
            6'd6:  u = f_mk(OP_MUL,  R_T0, R_D1 + 6'd2, R_D2);
            6'd7:  u = f_mk(OP_MUL,  R_T1, R_D1, R_D2 + 6'd2);
            6'd8:  u = f_mk(OP_SUB,  R_N + 6'd1, R_T0, R_T1);
            6'd9:  u = f_mk(OP_MUL,  R_T0, R_D1, R_D2 + 6'd1);
            6'd10: u = f_mk(OP_MUL,  R_T1, R_D1 + 6'd1, R_D2);
            6'd11: u = f_mk(OP_SUB,  R_N + 6'd2, R_T0, R_T1);
            6'd12: u = f_mk(OP_BNE,  L_LINE, R_N, R_ZR);
            6'd13: u = f_mk(OP_BNE,  L_LINE, R_N + 6'd1, R_ZR);
            6'd14: u = f_mk(OP_BEQ,  L_NEAR, R_N + 6'd2, R_ZR);
            // Closest points of the two lines.
            6'd15: u = f_mk(OP_VSUB, R_P31, R_P1, R_P3);
            6'd16: u = f_mk(OP_DOT,  R_S, R_P31, R_N);
            6'd17: u = f_mk(OP_DOT,  R_NN, R_N, R_N);
            6'd18: u = f_mk(OP_MUL,  R_T0, R_S, R_S);
            6'd19: u = f_mk(OP_MUL,  R_T1, R_R2, R_NN);
            6'd20: u = f_mk(OP_BGT,  L_MISS, R_T0, R_T1);
            6'd21: u = f_mk(OP_DOT,  R_D21, R_D2, R_D1);
            6'd22: u = f_mk(OP_DOT,  R_D22, R_D2, R_D2);
            6'd23: u = f_mk(OP_DOT,  R_D11, R_D1, R_D1);
            6'd24: u = f_mk(OP_DOT,  R_E2, R_P31, R_D2);
            6'd25: u = f_mk(OP_DOT,  R_E1, R_P31, R_D1);
            6'd26: u = f_mk(OP_MUL,  R_T0, R_E2, R_D21);
            6'd27: u = f_mk(OP_MUL,  R_T1, R_E1, R_D22);
            6'd28: u = f_mk(OP_SUB,  R_NA, R_T0, R_T1);
            6'd29: u = f_mk(OP_MUL,  R_T0, R_E2, R_D11);
            6'd30: u = f_mk(OP_MUL,  R_T1, R_E1, R_D21);
            6'd31: u = f_mk(OP_SUB,  R_NB, R_T0, R_T1);
            6'd32: u = f_mk(OP_BLE,  L_NEAR, R_NA, R_ZR);
            6'd33: u = f_mk(OP_BGE,  L_NEAR, R_NA, R_NN);
            6'd34: u = f_mk(OP_BLE,  L_NEAR, R_NB, R_ZR);
            6'd35: u = f_mk(OP_BGE,  L_NEAR, R_NB, R_NN);
            6'd36: u = f_mk(OP_HIT,  6'd0, 6'd0, 6'd0);
            // One endpoint against the other segment, clamped projection.
            6'd37: u = f_mk(OP_VSUB, R_W, R_VQ, R_VO);
            6'd38: u = f_mk(OP_DOT,  R_A, R_W, R_VD);
            6'd39: u = f_mk(OP_DOT,  R_B, R_VD, R_VD);
            6'd40: u = f_mk(OP_DOT,  R_WW, R_W, R_W);
            6'd41: u = f_mk(OP_BEQ,  L_CMPW, R_B, R_ZR);
            6'd42: u = f_mk(OP_BLE,  L_CMPW, R_A, R_ZR);
            6'd43: u = f_mk(OP_BGE,  L_ENDP, R_A, R_B);
            6'd44: u = f_mk(OP_MUL,  R_T0, R_WW, R_B);
            6'd45: u = f_mk(OP_MUL,  R_T1, R_A, R_A);
            6'd46: u = f_mk(OP_SUB,  R_T0, R_T0, R_T1);
            6'd47: u = f_mk(OP_MUL,  R_T1, R_R2, R_B);
            6'd48: u = f_mk(OP_BLT,  L_HIT, R_T0, R_T1);
            6'd49: u = f_mk(OP_NXT,  6'd0, 6'd0, 6'd0);
            6'd50: u = f_mk(OP_BLT,  L_HIT, R_WW, R_R2);
            6'd51: u = f_mk(OP_NXT,  6'd0, 6'd0, 6'd0);
            6'd52: u = f_mk(OP_VSUB, R_E, R_W, R_VD);
            6'd53: u = f_mk(OP_DOT,  R_T0, R_E, R_E);
            6'd54: u = f_mk(OP_BLT,  L_HIT, R_T0, R_R2);
            6'd55: u = f_mk(OP_NXT,  6'd0, 6'd0, 6'd0);
            default: u = f_mk(OP_MISS, 6'd0, 6'd0, 6'd0);
        endcase
        return u;
    endfunction

endpackage

// File: rtl/core/sppt_front.sv
module sppt_front
    import sppt_pkg::*;
#(
    parameter int COORD_BITS = 32
) (
    input  logic                                             i_s_tvalid,
    input  logic                                             i_clk,
    output logic                                             o_s_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z, radius, zero fill
    input  logic [((6*COORD_BITS+RADIUS_BITS+7)/8)*8-1:0]    i_s_tdata,
    input  logic                                             i_s_tlast,
    input  logic                                             i_full,
    output logic                                             o_push,
    output logic [12*COORD_BITS+RADIUS_BITS:0]               o_job
);

    logic [6*COORD_BITS-1:0] r_held;
    logic [RADIUS_BITS-1:0]  r_held_radius;
    logic                    accept;

    // A transfer is taken whenever the job queue has room.
    assign o_s_tready = ~i_full;
    assign accept     = i_s_tvalid & ~i_full;
    assign o_push     = accept & i_s_tlast;

    // A job is the held segment, the new segment and the radius sum.
    assign o_job = {(RADIUS_BITS+1)'(r_held_radius)
                        + (RADIUS_BITS+1)'(i_s_tdata[6*COORD_BITS +: RADIUS_BITS]),
                    i_s_tdata[6*COORD_BITS-1:0], r_held};

    // The first segment of a pair is held until its partner arrives.
    always_ff @(posedge i_clk) begin
        if (accept && !i_s_tlast) begin
            r_held        <= i_s_tdata[6*COORD_BITS-1:0];
            r_held_radius <= i_s_tdata[6*COORD_BITS +: RADIUS_BITS];
        end
    end

endmodule

// File: rtl/core/sppt_fifo.sv
module sppt_fifo
    import sppt_pkg::*;
#(
    parameter int WIDTH = 416
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_valid,
    output logic             o_full
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_count;

    assign o_data  = r_mem[r_rp];
    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);

    // Two-entry queue between the front and the back end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// File: rtl/core/sppt_back.sv
module sppt_back
    import sppt_pkg::*;
#(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_job_valid,
    input  logic [12*COORD_BITS+RADIUS_BITS:0]   i_job,
    output logic                                 o_pop,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic                                 o_hit
);

    // Common exact scale for coordinates and radii, and the working width.
    localparam int UP  = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam int UP2 = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
    localparam int CW  = COORD_BITS + UP;
    localparam int RW  = RADIUS_BITS + 1 + UP2;
    localparam int WA  = 6 * CW + 7;
    localparam int WB  = 4 * CW + 2 * RW + 5;
    localparam int W   = ((WA > WB) ? WA : WB) + 2;

    t_bstate          r_state, n_state;
    logic [5:0]       r_pc, n_pc;
    logic [1:0]       r_k, n_k;
    logic [1:0]       r_pass, n_pass;
    logic [3:0]       r_cnt, n_cnt;
    logic [W-1:0]     r_prod, n_prod;
    logic [W-1:0]     r_ma, n_ma;
    logic [W-1:0]     r_mb, n_mb;
    logic             r_res, n_res;
    logic             r_ovalid, n_ovalid;
    logic             r_hit, n_hit;

    logic [W-1:0]     r_rf [64];
    logic [W-1:0]     r_rda;
    logic [W-1:0]     r_rdb;
    logic             we;
    logic [5:0]       wa;
    logic [W-1:0]     wd;
    logic [5:0]       ra;
    logic [5:0]       rb;

    t_instr                  ins;
    logic                    last;
    logic                    lt;
    logic                    eq;
    logic                    take;
    logic [COORD_BITS-1:0]   coord;
    logic [RADIUS_BITS:0]    rsum;
    logic [W-1:0]            loadval;

    // Resolve the endpoint-pass aliases to physical registers.
    function automatic logic [5:0] f_map(input logic [5:0] la, input logic [1:0] pass);
        logic [5:0] res;
        if (la >= R_VD) begin
            res = (pass[1] ? R_D1 : R_D2) + (la - R_VD);
        end else if (la >= R_VO) begin
            res = (pass[1] ? R_P1 : R_P3) + (la - R_VO);
        end else if (la >= R_VQ) begin
            res = {3'b000, pass, 1'b0} + {4'b0000, pass} + (la - R_VQ);
        end else begin
            res = la;
        end
        return res;
    endfunction

    assign o_m_tvalid = r_ovalid;
    assign o_hit      = r_hit;

    // Register file with one write port and two registered read ports.
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_rf[wa] <= wd;
        end
        r_rda <= r_rf[ra];
        r_rdb <= r_rf[rb];
    end

    // Decode, operand addresses and the values loaded from a job.
    always_comb begin
        ins   = f_ucode(r_pc);
        last  = (ins.op == OP_VSUB || ins.op == OP_DOT) ? (r_k == 2'd2) : 1'b1;
        ra    = f_map(ins.a + {4'b0000, r_k}, r_pass);
        rb    = f_map(ins.b + {4'b0000, r_k}, r_pass);
        lt    = $signed(r_rda) < $signed(r_rdb);
        eq    = (r_rda == r_rdb);
        case (ins.op)
            OP_BLT:  take = lt;
            OP_BLE:  take = lt | eq;
            OP_BGT:  take = ~lt & ~eq;
            OP_BGE:  take = ~lt;
            OP_BEQ:  take = eq;
            OP_BNE:  take = ~eq;
            default: take = 1'b0;
        endcase
        coord = i_job[r_cnt*COORD_BITS +: COORD_BITS];
        rsum  = i_job[12*COORD_BITS +: RADIUS_BITS+1];
        if ({2'b00, r_cnt} == R_RS) begin
            loadval = {{(W-RADIUS_BITS-1){1'b0}}, rsum} << UP2;
        end else if ({2'b00, r_cnt} == R_ZR) begin
            loadval = '0;
        end else begin
            loadval = {{(W-COORD_BITS){coord[COORD_BITS-1]}}, coord} << UP;
        end
    end

    // Sequencer: load a job, then run the program one step at a time.
    always_comb begin
        n_state  = r_state;
        n_pc     = r_pc;
        n_k      = r_k;
        n_pass   = r_pass;
        n_cnt    = r_cnt;
        n_prod   = r_prod;
        n_ma     = r_ma;
        n_mb     = r_mb;
        n_res    = r_res;
        n_hit    = r_hit;
        n_ovalid = r_ovalid & ~i_m_tready;
        we       = 1'b0;
        wa       = ins.d;
        wd       = r_rda - r_rdb;
        o_pop    = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (i_job_valid) begin
                    n_cnt   = 4'd0;
                    n_state = B_LOAD;
                end
            end
            B_LOAD: begin
                we = 1'b1;
                wa = {2'b00, r_cnt};
                wd = loadval;
                if ({2'b00, r_cnt} == R_ZR) begin
                    o_pop   = 1'b1;
                    n_pc    = 6'd0;
                    n_k     = 2'd0;
                    n_pass  = 2'd0;
                    n_state = B_RD;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            B_RD: begin
                n_state = B_EX;
            end
            B_EX: begin
                n_state = B_RD;
                case (ins.op)
                    OP_SUB, OP_VSUB: begin
                        we = 1'b1;
                        wa = ins.d + {4'b0000, r_k};
                        if (last) begin
                            n_pc = r_pc + 6'd1;
                            n_k  = 2'd0;
                        end else begin
                            n_k = r_k + 2'd1;
                        end
                    end
                    OP_MUL, OP_DOT: begin
                        // Sign of the multiplier moves onto the multiplicand.
                        n_prod  = (r_k == 2'd0) ? '0 : r_prod;
                        n_ma    = r_rdb[W-1] ? -r_rda : r_rda;
                        n_mb    = r_rdb[W-1] ? -r_rdb : r_rdb;
                        n_state = B_MUL;
                    end
                    OP_HIT: begin
                        n_res   = 1'b1;
                        n_state = B_DONE;
                    end
                    OP_MISS: begin
                        n_res   = 1'b0;
                        n_state = B_DONE;
                    end
                    OP_NXT: begin
                        if (r_pass != 2'd3) begin
                            n_pass = r_pass + 2'd1;
                            n_pc   = L_NEAR;
                        end else begin
                            n_res   = 1'b0;
                            n_state = B_DONE;
                        end
                    end
                    default: begin
                        n_pc = take ? ins.d : r_pc + 6'd1;
                    end
                endcase
            end
            B_MUL: begin
                // Shift-add multiply, done when the multiplier runs out of bits.
                if (r_mb == '0) begin
                    n_state = B_RD;
                    if (last) begin
                        we   = 1'b1;
                        wa   = ins.d;
                        wd   = r_prod;
                        n_pc = r_pc + 6'd1;
                        n_k  = 2'd0;
                    end else begin
                        n_k = r_k + 2'd1;
                    end
                end else begin
                    if (r_mb[0]) begin
                        n_prod = r_prod + r_ma;
                    end
                    n_ma = r_ma << 1;
                    n_mb = r_mb >> 1;
                end
            end
            B_DONE: begin
                if (!r_ovalid || i_m_tready) begin
                    n_ovalid = 1'b1;
                    n_hit    = r_res;
                    n_state  = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pc   <= n_pc;
        r_k    <= n_k;
        r_pass <= n_pass;
        r_cnt  <= n_cnt;
        r_prod <= n_prod;
        r_ma   <= n_ma;
        r_mb   <= n_mb;
        r_res  <= n_res;
        r_hit  <= n_hit;
    end

endmodule

// File: rtl/core/segment_pair_proximity_test_top.sv
// Capsule pair proximity test. Items arrive on the slave stream, one segment
// per transfer with its radius; tlast low holds the segment, tlast high tests
// it against the held one and yields one result transfer on the master stream
// (hit in bit 0 of tdata). A held segment stays until the next tlast-low item.
// The front takes a transfer whenever its two-entry job queue has room, so up
// to two tests may wait while the back end works. The back end loads a job
// into its register file, then runs a short program one step at a time: each
// step reads its operands and then executes, and each product runs through a
// shift-add multiplier until the multiplier operand runs out of bits. That
// multiplier dominates the time a test takes, which depends on the magnitudes
// of the coordinates and which branch is taken; one test runs at a time.
// The result sits in an output register; while the receiver stalls, the back
// end holds its next result and the front keeps filling the queue. Reset
// empties the queue and drops any pending result; the held segment is
// undefined until the first tlast-low transfer.
module segment_pair_proximity_test_top
    import sppt_pkg::*;
#(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_s_tvalid,
    output logic                                          o_s_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z, radius, zero fill
    input  logic [((6*COORD_BITS+RADIUS_BITS+7)/8)*8-1:0] i_s_tdata,
    // is_second
    input  logic                                          i_s_tlast,
    output logic                                          o_m_tvalid,
    input  logic                                          i_m_tready,
    // hit, zero fill
    output logic [7:0]                                    o_m_tdata
);

    localparam int JW = 12 * COORD_BITS + RADIUS_BITS + 1;

    logic          push;
    logic [JW-1:0] job_in;
    logic [JW-1:0] job_out;
    logic          job_valid;
    logic          full;
    logic          pop;
    logic          hit;

    assign o_m_tdata = {7'b0000000, hit};

    sppt_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_full     (full),
        .o_push     (push),
        .o_job      (job_in)
    );

    sppt_fifo #(
        .WIDTH (JW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .i_pop   (pop),
        .o_data  (job_out),
        .o_valid (job_valid),
        .o_full  (full)
    );

    sppt_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job_out),
        .o_pop       (pop),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_hit       (hit)
    );

endmodule
